>>> src/mrpt_pkg.sv
`timescale 1ns / 1ps
package mrpt_pkg;
  localparam int NumberBits = 63;
  localparam int BitCntW = $clog2(NumberBits + 1);
  localparam int NumBases = 7;
  localparam int BaseIdxW = 3;

  typedef logic [NumberBits-1:0] word_t;

  // Witness bases, exact for every 64-bit value
  function automatic word_t base_value(input logic [BaseIdxW-1:0] idx);
    word_t v;
    case (idx)
      3'd0: v = word_t'(64'd2);
      3'd1: v = word_t'(64'd325);
      3'd2: v = word_t'(64'd9375);
      3'd3: v = word_t'(64'd28178);
      3'd4: v = word_t'(64'd450775);
      3'd5: v = word_t'(64'd9780504);
      3'd6: v = word_t'(64'd1795265022);
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic start;
    logic done;
  } mm_ctl_t;
endpackage

>>> src/mrpt_mulmod.sv
`timescale 1ns / 1ps
// Bit-serial a * b mod m: one multiplier bit per cycle, MSB first.
module mrpt_mulmod (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  mrpt_pkg::word_t       a,
  input  mrpt_pkg::word_t       b,
  input  mrpt_pkg::word_t       m,
  output logic                  done,
  output mrpt_pkg::word_t       p
);
  logic                         busy;
  logic [mrpt_pkg::BitCntW-1:0] cnt;
  mrpt_pkg::word_t              acc, opa, opb, mod;
  logic [mrpt_pkg::NumberBits:0] dbl, dbl_r, add, add_r;
  mrpt_pkg::word_t              acc_next;

  always_comb begin
    dbl = {1'b0, acc} + {1'b0, acc};
    dbl_r = (dbl >= {1'b0, mod}) ? dbl - {1'b0, mod} : dbl;
    add = dbl_r + {1'b0, opa};
    add_r = (add >= {1'b0, mod}) ? add - {1'b0, mod} : add;
    acc_next = opb[mrpt_pkg::NumberBits-1] ? add_r[mrpt_pkg::NumberBits-1:0]
                                           : dbl_r[mrpt_pkg::NumberBits-1:0];
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= mrpt_pkg::BitCntW'(mrpt_pkg::NumberBits);
      acc  <= '0;
      opa  <= a;
      opb  <= b;
      mod  <= m;
    end else if (busy) begin
      acc <= acc_next;
      opb <= opb << 1;
      cnt <= cnt - 1'b1;
      if (cnt == mrpt_pkg::BitCntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // the finished product sits in the accumulator once done is raised
  assign p = acc;
endmodule

>>> src/miller_rabin_prime_test_top.sv
`timescale 1ns / 1ps
// Deterministic Miller-Rabin primality test for a 63-bit candidate.
// Input channel: candidate_valid / candidate_stall, payload candidate.
// Output channel: result_valid / result_stall, payload is_prime.
// A request is taken only when the block is idle; one result follows.
// Values below 2, and multiples of 2 or 3, are settled right after the
// mod-6 pass.
// Others run seven bases; each modular product runs on the single
// bit-serial multiply-and-reduce unit (launched by a start pulse, handed
// back on done); when a zero exponent bit is seen, the speculative
// multiply is dropped. A full test costs up to about 7 * 126 products,
// so the multiplier unit sets the worst-case time.
// The candidate is reduced mod 6 and each base mod n by bit-serial
// shift-subtract, over all NumberBits bits of each.
// Reset returns the sequencer to idle and drops any pending result.
// When the receiver stalls, hold is_prime and result_valid; the block
// takes no new request until the result is delivered.
module miller_rabin_prime_test_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        candidate_valid,
  output logic        candidate_stall,
  input  logic [62:0] candidate,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        is_prime
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD6  = 4'd1;
  localparam logic [3:0] S_PRE   = 4'd2;
  localparam logic [3:0] S_BASE  = 4'd3;
  localparam logic [3:0] S_BRED  = 4'd4;
  localparam logic [3:0] S_PMUL  = 4'd5;
  localparam logic [3:0] S_PWAIT = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_SQ    = 4'd8;
  localparam logic [3:0] S_SQW   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam int W = mrpt_pkg::NumberBits;

  logic [3:0]                   state;
  mrpt_pkg::word_t              n, d, e, acc, bas, x, rem, sh;
  logic [2:0]                   r6;
  logic [mrpt_pkg::BitCntW-1:0] cnt, s, j;
  logic [mrpt_pkg::BaseIdxW-1:0] k;
  logic                         phase;
  logic                         mm_start;
  mrpt_pkg::mm_ctl_t            mm;
  mrpt_pkg::word_t              mm_a, mm_b, mm_p;
  logic [W:0]                   rem2;
  logic [3:0]                   r6x;
  mrpt_pkg::word_t              nm1;

  assign nm1 = n - 1'b1;
  assign mm.start = mm_start;

  mrpt_mulmod u_mm (
    .clk(clk), .rst(rst), .start(mm.start), .a(mm_a), .b(mm_b), .m(n),
    .done(mm.done), .p(mm_p)
  );

  assign rem2 = {rem, sh[W-1]};
  assign r6x  = {r6, sh[W-1]};
  assign candidate_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    mm_start <= 1'b0;
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (candidate_valid) begin
            n     <= candidate;
            sh    <= candidate;
            r6    <= '0;
            cnt   <= mrpt_pkg::BitCntW'(W);
            state <= S_MOD6;
          end
        end
        S_MOD6: begin
          r6  <= (r6x >= 4'd6) ? 3'(r6x - 4'd6) : r6x[2:0];
          sh  <= sh << 1;
          cnt <= cnt - 1'b1;
          if (cnt == mrpt_pkg::BitCntW'(1)) begin
            state <= S_PRE;
          end
        end
        S_PRE: begin
          d <= nm1;
          s <= '0;
          k <= '0;
          if (n < mrpt_pkg::word_t'(2)) begin
            is_prime <= 1'b0;
            state    <= S_DONE;
          end else if (r6 != 3'd1 && r6 != 3'd5) begin
            is_prime <= (n == mrpt_pkg::word_t'(2)) || (n == mrpt_pkg::word_t'(3));
            state    <= S_DONE;
          end else begin
            is_prime <= 1'b1;
            phase    <= 1'b0;
            state    <= S_BASE;
          end
        end
        S_BASE: begin
          // strip factors of two first, one per cycle
          if (!phase) begin
            if (!d[0]) begin
              d <= d >> 1;
              s <= s + 1'b1;
            end else begin
              phase <= 1'b1;
            end
          end else if (k == 3'(mrpt_pkg::NumBases)) begin
            state <= S_DONE;
          end else begin
            sh    <= mrpt_pkg::base_value(k);
            rem   <= '0;
            cnt   <= mrpt_pkg::BitCntW'(W);
            state <= S_BRED;
          end
        end
        S_BRED: begin
          rem <= (rem2 >= {1'b0, n}) ? W'(rem2 - {1'b0, n}) : rem2[W-1:0];
          sh  <= sh << 1;
          cnt <= cnt - 1'b1;
          if (cnt == mrpt_pkg::BitCntW'(1)) begin
            state <= S_PMUL;
            e     <= d;
            acc   <= mrpt_pkg::word_t'(1);
            phase <= 1'b0;
          end
        end
        S_PMUL: begin
          if (rem == '0) begin
            k     <= k + 1'b1;
            state <= S_BASE;
          end else begin
            bas   <= rem;
            rem   <= '1;
            state <= S_PWAIT;
            mm_a  <= acc;
            mm_b  <= rem;
            mm_start <= 1'b1;
            phase <= 1'b0;
          end
        end
        S_PWAIT: begin
          // phase 0: acc*base (if e odd), phase 1: base*base
          if (!phase && !mm_start && !e[0]) begin
            mm_a <= bas; mm_b <= bas; mm_start <= 1'b1; phase <= 1'b1;
          end else if (mm.done) begin
            if (!phase) begin
              acc <= mm_p;
              mm_a <= bas; mm_b <= bas; mm_start <= 1'b1; phase <= 1'b1;
            end else begin
              bas <= mm_p;
              e   <= e >> 1;
              if ((e >> 1) == '0) begin
                x     <= acc;
                state <= S_CHK;
              end else begin
                mm_a <= acc; mm_b <= mm_p; mm_start <= 1'b1; phase <= 1'b0;
              end
            end
          end
        end
        S_CHK: begin
          j <= mrpt_pkg::BitCntW'(1);
          if (x == mrpt_pkg::word_t'(1) || x == nm1) begin
            k <= k + 1'b1;
            phase <= 1'b1;
            state <= S_BASE;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (j >= s) begin
            is_prime <= 1'b0;
            state    <= S_DONE;
          end else begin
            mm_a <= x; mm_b <= x; mm_start <= 1'b1;
            state <= S_SQW;
          end
        end
        S_SQW: begin
          if (mm.done) begin
            x <= mm_p;
            j <= j + 1'b1;
            if (mm_p == nm1) begin
              k <= k + 1'b1;
              phase <= 1'b1;
              state <= S_BASE;
            end else if (mm_p == mrpt_pkg::word_t'(1)) begin
              is_prime <= 1'b0;
              state    <= S_DONE;
            end else begin
              state <= S_SQ;
            end
          end
        end
        S_DONE: begin
          if (!result_valid) begin
            result_valid <= 1'b1;
          end else if (!result_stall) begin
            result_valid <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the product unit only finishes in the exponent and squaring phases
  assert property (@(posedge clk) disable iff (rst)
    mm.done |-> (state == S_PWAIT || state == S_SQW))
    else $error("product finished outside a multiply phase");
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> state == S_DONE)
    else $error("result shown outside done state");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PRE) |-> r6 < 3'd6)
    else $error("mod-6 residue out of range");
endmodule
